// ----- src/rta_pkg.sv -----
// rta_pkg: shared widths, status struct and digit glyph helpers for the
// radix to ascii converter. No dependencies.
`default_nettype none

package rta_pkg;

   // field widths
   localparam int VALUE_W = 64;
   localparam int RADIX_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 7;

   // division runs one quotient bit per cycle
   localparam int STEP_W = $clog2(VALUE_W);

   // radix limits
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   // default digit store depth
   localparam int MAX_DIGITS_DEFAULT = 64;

   // digit glyph tables
   localparam logic [CHAR_W-1:0] UPPER_GLYPHS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };
   localparam logic [CHAR_W-1:0] LOWER_GLYPHS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
   };

   // divider status toward the sequencer
   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   // clamp a raw radix into 2..16
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   // digit value to ascii
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d,
                                                input logic up);
      return up ? UPPER_GLYPHS[d] : LOWER_GLYPHS[d];
   endfunction

endpackage

`default_nettype wire

// ----- src/rta_divider.sv -----
// rta_divider: bit-serial restoring division of a 64-bit word by a small radix.
// One quotient bit per cycle. Depends on rta_pkg.
`default_nettype none

module rta_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rta_pkg::VALUE_W-1:0]    dividend,
   input  wire logic [rta_pkg::RADIX_W-1:0]    divisor,
   output rta_pkg::div_status_type             status,
   output logic      [rta_pkg::VALUE_W-1:0]    quotient
);
   import rta_pkg::*;

   logic [VALUE_W-1:0] q_ff;
   logic [DIGIT_W-1:0] rem_ff;
   logic [RADIX_W-1:0] div_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               run_ff;
   logic               done_ff;

   logic [RADIX_W-1:0] rem_sh;
   logic [RADIX_W-1:0] rem_diff;
   logic               q_bit;
   logic [DIGIT_W-1:0] rem_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh   = {rem_ff, q_ff[VALUE_W-1]};
      rem_diff = rem_sh - div_ff;
      q_bit    = (rem_sh >= div_ff);
      rem_in   = q_bit ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         q_ff   <= {q_ff[VALUE_W-2:0], q_bit};
         rem_ff <= rem_in;
      end
   end

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;
   assign quotient         = q_ff;

endmodule

`default_nettype wire

// ----- src/rta_digit_store.sv -----
// rta_digit_store: digit memory, one write port and one registered read port.
// Depends on rta_pkg.
`default_nettype none

module rta_digit_store #(
   parameter int DEPTH = rta_pkg::MAX_DIGITS_DEFAULT,
   parameter int IDX_W = 6
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [IDX_W-1:0]              wr_addr,
   input  wire logic [rta_pkg::DIGIT_W-1:0]   wr_data,
   input  wire logic                          rd_en,
   input  wire logic [IDX_W-1:0]              rd_addr,
   output logic      [rta_pkg::DIGIT_W-1:0]   rd_data
);
   import rta_pkg::*;

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/radix_to_ascii_converter.sv -----
// radix_to_ascii_converter: top level, sequencer around the bit-serial divider
// and the digit store. Depends on rta_pkg, rta_divider, rta_digit_store.
//
// Converts one unsigned 64-bit word at a time into its ASCII digits in radix
// 2..16 (out-of-range radix clamped), most significant digit first, with
// rsp_last on the final digit; zero gives a single '0'. Each digit comes from
// a one-bit-per-cycle division by the radix and is then written to the
// store, and any further division starts as it is written; the digits are
// then read back from the store, each through a read state and then a show
// state that holds the digit while the output is stalled. A full-width
// decimal value has 20 digits, radix 2 up to 64. A new word is taken only
// once the last digit of the previous one has been delivered.
`default_nettype none

module radix_to_ascii_converter #(
   parameter int MAX_DIGITS = rta_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rta_pkg::VALUE_W-1:0]   req_value,
   input  wire logic [rta_pkg::RADIX_W-1:0]   req_radix,
   input  wire logic                          req_upper_case,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [rta_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                               rsp_last
);
   import rta_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_SHOW
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [RADIX_W-1:0] radix_ff;
   logic               upper_ff;

   div_status_type     div_stat;
   logic [VALUE_W-1:0] quotient;
   logic [DIGIT_W-1:0] rd_data;

   logic               req_accept;
   logic               rsp_accept;
   logic [CNT_W-1:0]   cnt_next;
   logic               finish;
   logic               div_start;
   logic [VALUE_W-1:0] div_dividend;
   logic [RADIX_W-1:0] div_radix;
   logic               wr_en;
   logic               rd_en;

   // handshakes
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == S_SHOW);
   assign rsp_accept = rsp_valid && !rsp_stall;

   // digit loop control
   always_comb begin
      cnt_next     = cnt_ff + CNT_W'(1);
      finish       = (quotient == '0) || (cnt_next == CNT_W'(MAX_DIGITS));
      wr_en        = (state_ff == S_DIV) && div_stat.done;
      div_start    = req_accept || (wr_en && !finish);
      div_dividend = (state_ff == S_IDLE) ? req_value : quotient;
      div_radix    = (state_ff == S_IDLE) ? clamp_radix(req_radix) : radix_ff;
      rd_en        = (state_ff == S_READ);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
         radix_ff  <= RADIX_MIN;
         upper_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_DIV;
                  cnt_ff   <= '0;
                  radix_ff <= clamp_radix(req_radix);
                  upper_ff <= req_upper_case;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  cnt_ff <= cnt_next;
                  if (finish) begin
                     rd_idx_ff <= cnt_ff[IDX_W-1:0];
                     state_ff  <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_SHOW;
            end
            S_SHOW: begin
               if (rsp_accept) begin
                  if (rd_idx_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     rd_idx_ff <= rd_idx_ff - IDX_W'(1);
                     state_ff  <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   rta_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_radix),
      .status   (div_stat),
      .quotient (quotient)
   );

   rta_digit_store #(
      .DEPTH (MAX_DIGITS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (div_stat.remainder),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // output word
   assign rsp_digit_char = glyph(rd_data, upper_ff);
   assign rsp_last       = (rd_idx_ff == '0);

   // divider only finishes while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   // an accepted word starts a fresh digit count
   a_accept_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DIV) && (cnt_ff == '0))
      else $error("accepted word did not start a new conversion");

   // the last digit frees the input side right away
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last) |=> !req_stall)
      else $error("input still stalled after the last digit");

   // read index always points inside the digits produced
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CNT_W'(rd_idx_ff) < cnt_ff))
      else $error("read index beyond stored digits");

endmodule

`default_nettype wire
